FILE: rtl/dmm_pkg.sv
package dmm_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_INNER = 16;
  localparam int MAX_COLS  = 16;

  localparam int DIM_W  = 4;
  localparam int SIZE_W = 5;
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 40;
  localparam int RES_W  = 32;

  typedef enum logic [2:0] {
    OP_LD_A  = 3'd0,
    OP_LD_B  = 3'd1,
    OP_LD_G  = 3'd2,
    OP_RUN   = 3'd3,
    OP_RD_C  = 3'd4,
    OP_RD_DA = 3'd5,
    OP_RD_DB = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_ROWS  = 2'd1,
    REG_INNER = 2'd2,
    REG_COLS  = 2'd3
  } reg_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_load;
  } mac_ctrl_t;

  // Clamped size minus one, as a loop bound.
  function automatic logic [DIM_W-1:0] size_last(input logic [SIZE_W-1:0] v,
                                                 input int max);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > max) begin
      r = DIM_W'(max - 1);
    end else begin
      r = DIM_W'(v - SIZE_W'(1));
    end
    return r;
  endfunction

  function automatic logic [RES_W-1:0] sat_q16(input logic signed [ACC_W-1:0] v);
    logic [RES_W-1:0] r;
    if (v > ACC_W'(signed'({1'b0, {(RES_W-1){1'b1}}}))) begin
      r = {1'b0, {(RES_W-1){1'b1}}};
    end else if (v < -(ACC_W'(signed'({1'b0, {(RES_W-1){1'b1}}}))) - ACC_W'(1)) begin
      r = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/dense_matmul_fwd_bwd.sv
// Loads give no beat; a new item may follow at once.
// A read first registers the memory entry, then registers the saturated beat.
// A run first clears the result stores it writes, then steps each multiply-accumulate of
// the single shared MAC through read, multiply and accumulate states, writes each result
// element and ends with a done beat; backward mode computes dA and then dB.
// Reset (async, active low) sets mode 0 and sizes 16 and starts a clear of all result
// stores; input is held off until the clear ends.
module dense_matmul_fwd_bwd (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         op_i,
  input  logic [dmm_pkg::DIM_W-1:0]          row_i,
  input  logic [dmm_pkg::DIM_W-1:0]          col_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [dmm_pkg::RES_W-1:0]   result_value_o,
  output logic                               done_res_o,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [3:0]                         paddr_i,
  input  logic [31:0]                        pwdata_i,
  output logic [31:0]                        prdata_o,
  output logic                               pready_o
);
  import dmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_RD, S_MUL, S_ACC, S_WR, S_DONE, S_CLR
  } state_e;

  typedef enum logic [1:0] {
    PH_C, PH_DA, PH_DB
  } phase_e;

  // Configuration registers.
  logic              mode_q;
  logic [SIZE_W-1:0] rows_q, inner_q, cols_q;
  logic              cfg_wr;
  reg_e              cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = reg_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      rows_q  <= SIZE_W'(MAX_ROWS);
      inner_q <= SIZE_W'(MAX_INNER);
      cols_q  <= SIZE_W'(MAX_COLS);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:  mode_q  <= pwdata_i[0];
        REG_ROWS:  rows_q  <= pwdata_i[SIZE_W-1:0];
        REG_INNER: inner_q <= pwdata_i[SIZE_W-1:0];
        REG_COLS:  cols_q  <= pwdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:  prdata_o = {31'd0, mode_q};
      REG_ROWS:  prdata_o = 32'(rows_q);
      REG_INNER: prdata_o = 32'(inner_q);
      REG_COLS:  prdata_o = 32'(cols_q);
      default:   prdata_o = '0;
    endcase
  end

  // Sequencer state.
  state_e            state_q;
  phase_e            phase_q;
  logic [DIM_W-1:0]  x_q, y_q, t_q;
  logic [ADDR_W-1:0] clr_q;
  logic              clr_c_q, clr_g_q;
  op_e               rd_op_q;
  logic              rd_inr_q;
  logic              out_valid_q, done_q;
  logic [RES_W-1:0]  out_value_q;

  logic in_fire;
  op_e  op;
  logic ld_a_ok, ld_b_ok, ld_g_ok, rd_inr;

  assign op         = op_e'(op_i);
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign ld_a_ok = ({1'b0, row_i} < SIZE_W'(MAX_ROWS))  && ({1'b0, col_i} < SIZE_W'(MAX_INNER));
  assign ld_b_ok = ({1'b0, row_i} < SIZE_W'(MAX_INNER)) && ({1'b0, col_i} < SIZE_W'(MAX_COLS));
  assign ld_g_ok = ({1'b0, row_i} < SIZE_W'(MAX_ROWS))  && ({1'b0, col_i} < SIZE_W'(MAX_COLS));

  always_comb begin
    case (op)
      OP_RD_C:  rd_inr = ld_g_ok;
      OP_RD_DA: rd_inr = ld_a_ok;
      OP_RD_DB: rd_inr = ld_b_ok;
      default:  rd_inr = 1'b0;
    endcase
  end

  // Loop bounds for the current phase.
  logic [DIM_W-1:0] m_last, n_last, p_last, x_last, y_last, t_last;
  assign m_last = size_last(rows_q,  MAX_ROWS);
  assign n_last = size_last(inner_q, MAX_INNER);
  assign p_last = size_last(cols_q,  MAX_COLS);

  always_comb begin
    case (phase_q)
      PH_C:    begin x_last = m_last; y_last = p_last; t_last = n_last; end
      PH_DA:   begin x_last = m_last; y_last = n_last; t_last = p_last; end
      PH_DB:   begin x_last = n_last; y_last = p_last; t_last = m_last; end
      default: begin x_last = m_last; y_last = p_last; t_last = n_last; end
    endcase
  end

  // Operand addresses: C = A*B, dA = dC*B^T, dB = A^T*dC.
  logic [ADDR_W-1:0] a_raddr, b_raddr, g_raddr, wr_addr, ld_addr;
  assign a_raddr = (phase_q == PH_DB) ? {t_q, x_q} : {x_q, t_q};
  assign b_raddr = (phase_q == PH_C)  ? {t_q, y_q} : {y_q, t_q};
  assign g_raddr = (phase_q == PH_DA) ? {x_q, t_q} : {t_q, y_q};
  assign wr_addr = {x_q, y_q};
  assign ld_addr = {row_i, col_i};

  // Operand memories.
  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  logic signed [ELEM_W-1:0] g_mem [DEPTH];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q, g_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && op == OP_LD_A && ld_a_ok) begin
      a_mem[ld_addr] <= value_i;
    end
    if (in_fire && op == OP_LD_B && ld_b_ok) begin
      b_mem[ld_addr] <= value_i;
    end
    if (in_fire && op == OP_LD_G && ld_g_ok) begin
      g_mem[ld_addr] <= value_i;
    end
    a_rd_q <= a_mem[a_raddr];
    b_rd_q <= b_mem[b_raddr];
    g_rd_q <= g_mem[g_raddr];
  end

  // Result memories. The clear pass walks every entry once, one per cycle,
  // so entries outside the used sizes read as zero after a run.
  logic signed [ACC_W-1:0] c_mem  [DEPTH];
  logic signed [ACC_W-1:0] da_mem [DEPTH];
  logic signed [ACC_W-1:0] db_mem [DEPTH];
  logic signed [ACC_W-1:0] c_rd_q, da_rd_q, db_rd_q;
  logic signed [ACC_W-1:0] acc;
  logic                    res_wr, clr_wr;

  assign res_wr = (state_q == S_WR);
  assign clr_wr = (state_q == S_CLR);

  always_ff @(posedge clk_i) begin
    if (clr_wr && clr_c_q) begin
      c_mem[clr_q] <= '0;
    end else if (res_wr && phase_q == PH_C) begin
      c_mem[wr_addr] <= acc;
    end
    if (clr_wr && clr_g_q) begin
      da_mem[clr_q] <= '0;
    end else if (res_wr && phase_q == PH_DA) begin
      da_mem[wr_addr] <= acc;
    end
    if (clr_wr && clr_g_q) begin
      db_mem[clr_q] <= '0;
    end else if (res_wr && phase_q == PH_DB) begin
      db_mem[wr_addr] <= acc;
    end
    c_rd_q  <= c_mem[ld_addr];
    da_rd_q <= da_mem[ld_addr];
    db_rd_q <= db_mem[ld_addr];
  end

  // Shared MAC.
  mac_ctrl_t                mac_ctrl;
  logic signed [ELEM_W-1:0] opx, opy;

  assign opx = (phase_q == PH_C)  ? a_rd_q : g_rd_q;
  assign opy = (phase_q == PH_DB) ? a_rd_q : b_rd_q;

  assign mac_ctrl.mul_en   = (state_q == S_MUL);
  assign mac_ctrl.acc_en   = (state_q == S_ACC);
  assign mac_ctrl.acc_load = (t_q == '0);

  dmm_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .opx_i  (opx),
    .opy_i  (opy),
    .acc_o  (acc)
  );

  // Read reply: pick the registered entry of the requested store.
  logic signed [ACC_W-1:0] rd_val;
  always_comb begin
    case (rd_op_q)
      OP_RD_C:  rd_val = c_rd_q;
      OP_RD_DA: rd_val = da_rd_q;
      OP_RD_DB: rd_val = db_rd_q;
      default:  rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Clear every result store before the first item is taken.
      state_q     <= S_CLR;
      phase_q     <= PH_C;
      x_q         <= '0;
      y_q         <= '0;
      t_q         <= '0;
      clr_q       <= '0;
      clr_c_q     <= 1'b1;
      clr_g_q     <= 1'b1;
      rd_op_q     <= OP_NONE;
      rd_inr_q    <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      out_value_q <= '0;
    end else begin
      // Drop the beat once taken; a new one below overrides.
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (op)
              OP_RUN: begin
                phase_q <= mode_q ? PH_DA : PH_C;
                x_q     <= '0;
                y_q     <= '0;
                t_q     <= '0;
                clr_q   <= '0;
                clr_c_q <= !mode_q;
                clr_g_q <= mode_q;
                state_q <= S_CLR;
              end
              OP_RD_C, OP_RD_DA, OP_RD_DB: begin
                rd_op_q  <= op;
                rd_inr_q <= rd_inr;
                state_q  <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == '1) begin
            // Both stores marked only after reset: go idle; a run goes on to compute.
            if (clr_c_q && clr_g_q) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RD;
            end
            clr_c_q <= 1'b0;
            clr_g_q <= 1'b0;
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          done_q      <= 1'b0;
          out_value_q <= rd_inr_q ? sat_q16(rd_val) : '0;
          state_q     <= S_IDLE;
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (t_q == t_last) begin
            state_q <= S_WR;
          end else begin
            t_q     <= t_q + DIM_W'(1);
            state_q <= S_RD;
          end
        end
        S_WR: begin
          t_q     <= '0;
          state_q <= S_RD;
          if (y_q == y_last) begin
            y_q <= '0;
            if (x_q == x_last) begin
              x_q <= '0;
              if (phase_q == PH_DA) begin
                phase_q <= PH_DB;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              x_q <= x_q + DIM_W'(1);
            end
          end else begin
            y_q <= y_q + DIM_W'(1);
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          done_q      <= 1'b1;
          out_value_q <= '0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign done_res_o     = done_q;

endmodule

FILE: rtl/dmm_mac.sv
module dmm_mac (
  input  logic                               clk_i,
  input  dmm_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]  opx_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0]  opy_i,
  output logic signed [dmm_pkg::ACC_W-1:0]   acc_o
);
  import dmm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_q);

  // Multiply, then accumulate in the following cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= opx_i * opy_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.acc_load ? prod_ext : acc_q + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/dmm_chk.sv
module dmm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_value_o,
  input logic        done_res_o
);
  import dmm_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A run holds off input until it is done.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && op_i == OP_RUN |=> !in_ready_o)
    else $error("input accepted right after run");

  // Hold a stalled beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("stalled beat changed");

  // Done beats carry zero.
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> result_value_o == '0)
    else $error("done beat with nonzero value");

  // A load never causes a beat.
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op_i == OP_LD_A || op_i == OP_LD_B || op_i == OP_LD_G) && !out_valid_o
    |=> !out_valid_o)
    else $error("beat after load");

endmodule

bind dense_matmul_fwd_bwd dmm_chk u_dmm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o),
  .done_res_o     (done_res_o)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the operand stores, the accumulators and
// the size registers, works out each reply when an input beat is accepted and
// checks the reply beats against those expectations in order.
class matmul_scoreboard;
  bit          mode_q;
  logic [4:0]  rows_q, inner_q, cols_q;
  int          opnd_a[16][16], opnd_b[16][16], opnd_g[16][16];
  bit          a_set[16][16], b_set[16][16], g_set[16][16];
  longint      prod[16][16], grad_a[16][16], grad_b[16][16];
  logic [31:0] exp_val[$];
  bit          exp_done[$];
  int          failures, checked, runs, loads, reads;

  function new();
    mode_q  = 1'b0;
    rows_q  = 5'd16;
    inner_q = 5'd16;
    cols_q  = 5'd16;
  endfunction

  // Zero counts as one, anything above the store size as the full size.
  function int eff(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  function logic [31:0] sat_q16(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function int pending();
    return exp_val.size();
  endfunction

  function void set_reg(dmm_pkg::reg_e idx, logic [31:0] v);
    case (idx)
      dmm_pkg::REG_MODE:  mode_q  = v[0];
      dmm_pkg::REG_ROWS:  rows_q  = v[4:0];
      dmm_pkg::REG_INNER: inner_q = v[4:0];
      dmm_pkg::REG_COLS:  cols_q  = v[4:0];
      default: ;
    endcase
  endfunction

  function void product_pass();
    int m, n, p;
    m = eff(rows_q);
    n = eff(inner_q);
    p = eff(cols_q);
    foreach (prod[i, k]) prod[i][k] = 0;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < p; k++)
          prod[i][k] += longint'(opnd_a[i][j]) * longint'(opnd_b[j][k]);
  endfunction

  function void gradient_pass();
    int m, n, p;
    longint sum, g;
    m = eff(rows_q);
    n = eff(inner_q);
    p = eff(cols_q);
    foreach (grad_a[i, j]) grad_a[i][j] = 0;
    foreach (grad_b[i, j]) grad_b[i][j] = 0;
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++) begin
        sum = 0;
        for (int k = 0; k < p; k++) begin
          g = opnd_g[i][k];
          sum += g * longint'(opnd_b[j][k]);
          grad_b[j][k] += g * longint'(opnd_a[i][j]);
        end
        grad_a[i][j] = sum;
      end
  endfunction

  function void note_input(dmm_pkg::op_e op, logic [3:0] r, logic [3:0] c,
                           logic signed [15:0] v);
    case (op)
      dmm_pkg::OP_LD_A: begin
        opnd_a[r][c] = v; a_set[r][c] = 1'b1; loads++;
      end
      dmm_pkg::OP_LD_B: begin
        opnd_b[r][c] = v; b_set[r][c] = 1'b1; loads++;
      end
      dmm_pkg::OP_LD_G: begin
        opnd_g[r][c] = v; g_set[r][c] = 1'b1; loads++;
      end
      dmm_pkg::OP_RUN: begin
        if (mode_q) gradient_pass();
        else product_pass();
        exp_val.push_back('0);
        exp_done.push_back(1'b1);
        runs++;
      end
      dmm_pkg::OP_RD_C, dmm_pkg::OP_RD_DA, dmm_pkg::OP_RD_DB: begin
        if (op == dmm_pkg::OP_RD_C) exp_val.push_back(sat_q16(prod[r][c]));
        else if (op == dmm_pkg::OP_RD_DA) exp_val.push_back(sat_q16(grad_a[r][c]));
        else exp_val.push_back(sat_q16(grad_b[r][c]));
        exp_done.push_back(1'b0);
        reads++;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [31:0] val, logic done);
    logic [31:0] ev;
    bit          ed;
    if (exp_val.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: reply beat with nothing expected: value %h done %b", val, done);
      return;
    end
    ev = exp_val.pop_front();
    ed = exp_done.pop_front();
    checked++;
    if (val !== ev || done !== ed) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: reply %0d: expected value %h done %b, got value %h done %b",
                 checked, ev, ed, val, done);
    end
  endfunction
endclass

module tb;
  import dmm_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam int N_PHASES = 22;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         op_i;
  logic [3:0]         row_i;
  logic [3:0]         col_i;
  logic signed [15:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] result_value_o;
  logic               done_res_o;
  logic               psel_i;
  logic               penable_i;
  logic               pwrite_i;
  logic [3:0]         paddr_i;
  logic [31:0]        pwdata_i;
  logic [31:0]        prdata_o;
  logic               pready_o;

  matmul_scoreboard sb;

  int cyc;
  int burst_left;
  int hold_reqs, hold_seen, hold_left;

  dense_matmul_fwd_bwd dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: rotate through always-ready, coin-flip and sparse patterns;
  // a hold request from the stimulus drops ready for a long stretch.
  // Also the watchdog on total run length.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((cyc / 400) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= (cyc % 5 == 0);
      endcase
    end
    if (cyc > LIMIT) begin
      $display("Timeout after %0d cycles", cyc);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every reply beat; values from before the edge are seen here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(result_value_o, done_res_o);
  end

  // Advance the sender's burst; at the end of a burst drop valid for a gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Offer one beat and hold it until accepted.
  task automatic send_item(op_e op, logic [3:0] r, logic [3:0] c, logic [15:0] v);
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(op, r, c, v);
    pace();
  endtask

  // Hold the sender until every reply is back, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] v);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(bit md, logic [4:0] r, logic [4:0] n, logic [4:0] c);
    cfg_write(REG_MODE, {31'd0, md});
    cfg_write(REG_ROWS, {27'd0, r});
    cfg_write(REG_INNER, {27'd0, n});
    cfg_write(REG_COLS, {27'd0, c});
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Load every operand the next run will touch that was never written.
  task automatic fill_operands();
    int m, n, p;
    m = sb.eff(sb.rows_q);
    n = sb.eff(sb.inner_q);
    p = sb.eff(sb.cols_q);
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++)
        if (!sb.a_set[i][j]) send_item(OP_LD_A, 4'(i), 4'(j), rand_value());
    for (int j = 0; j < n; j++)
      for (int k = 0; k < p; k++)
        if (!sb.b_set[j][k]) send_item(OP_LD_B, 4'(j), 4'(k), rand_value());
    if (sb.mode_q)
      for (int i = 0; i < m; i++)
        for (int k = 0; k < p; k++)
          if (!sb.g_set[i][k]) send_item(OP_LD_G, 4'(i), 4'(k), rand_value());
  endtask

  function automatic logic [3:0] pick_index(int lim);
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, lim - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic random_item();
    int   k;
    op_e  op;
    int   rl, cl;
    k = $urandom_range(0, 99);
    if (k < 30) begin
      op = op_e'($urandom_range(int'(OP_LD_A), int'(OP_LD_G)));
      send_item(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rand_value());
    end else if (k < 38) begin
      send_item(OP_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                16'($urandom_range(0, 65535)));
    end else if (k < 95) begin
      op = op_e'($urandom_range(int'(OP_RD_C), int'(OP_RD_DB)));
      rl = (op == OP_RD_DB) ? sb.eff(sb.inner_q) : sb.eff(sb.rows_q);
      cl = (op == OP_RD_DA) ? sb.eff(sb.inner_q) : sb.eff(sb.cols_q);
      send_item(op, pick_index(rl), pick_index(cl), 16'($urandom_range(0, 65535)));
    end else begin
      send_item(OP_NONE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    bit         md;
    logic [4:0] sr, sn, sc;
    sb = new();
    cyc = 0;
    burst_left = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_NONE;
    row_i = '0;
    col_i = '0;
    value_i = '0;
    out_ready_i = 1'b0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads before any run come back zero, then a 1x4 by 4x2
    // product of extremes that saturates one way in each column.
    send_item(OP_RD_C, 4'd15, 4'd15, 16'd0);
    send_item(OP_RD_DA, 4'd0, 4'd0, 16'd0);
    drain();
    configure(1'b0, 5'd1, 5'd4, 5'd2);
    for (int j = 0; j < 4; j++) begin
      send_item(OP_LD_A, 4'd0, 4'(j), 16'h7fff);
      send_item(OP_LD_B, 4'(j), 4'd0, 16'h7fff);
      send_item(OP_LD_B, 4'(j), 4'd1, 16'h8000);
    end
    send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
    send_item(OP_RD_C, 4'd0, 4'd0, 16'd0);
    send_item(OP_RD_C, 4'd0, 4'd1, 16'd0);
    send_item(OP_RD_C, 4'd15, 4'd15, 16'd0);
    send_item(OP_NONE, 4'd15, 4'd15, 16'hffff);
    send_item(OP_RD_DB, 4'd0, 4'd0, 16'd0);
    drain();

    // Random phases: new settings each time, extremes in the first few.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin md = 1'b0; sr = 5'd16; sn = 5'd16; sc = 5'd16; end
        1: begin md = 1'b1; sr = 5'd16; sn = 5'd16; sc = 5'd2; end
        2: begin md = 1'($urandom_range(0, 1)); sr = 5'd0; sn = 5'd0; sc = 5'd0; end
        3: begin md = 1'b0; sr = 5'd31; sn = 5'd17; sc = 5'd20; end
        4: begin md = 1'b1; sr = 5'd1; sn = 5'd1; sc = 5'd1; end
        default: begin
          md = 1'($urandom_range(0, 1));
          sr = ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(1, 5));
          sn = ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(1, 5));
          sc = ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(1, 5));
        end
      endcase
      configure(md, sr, sn, sc);
      fill_operands();
      send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
      if (ph == 5) begin
        // Hold the receiver off and keep offering reads until input stalls.
        hold_reqs++;
        burst_left = 100;
        repeat (30) send_item(md ? OP_RD_DA : OP_RD_C, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 16'd0);
      end
      repeat (7) random_item();
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d loads, %0d runs and %0d reads over %0d settings in both modes,",
             sb.loads, sb.runs, sb.reads, N_PHASES + 1);
    $display("sizes from one to full with clamping, saturation and stalls on both sides.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d replies still expected", sb.failures, sb.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dmm_pkg.sv
rtl/dmm_mac.sv
rtl/dense_matmul_fwd_bwd.sv
rtl/dmm_chk.sv
tb/tb.sv
